// ===== hw/rtl/spes_pkg.sv =====
package spes_pkg;

  localparam int unsigned CAPACITY_DEF = 512;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PTR_W = 32;
  localparam int unsigned POS_W = 9;
  localparam int unsigned CNT_W = 10;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PTR_W-1:0] ptr;
    logic internal;
    logic fence;
  } entry_t;

endpackage

// ===== hw/rtl/sorted_page_entry_store.sv =====
// Channel   Signals                                              Direction
// command   start, busy, command, key_in, ptr_in, fence_in,      in
//           internal_in
// result    done, status, position, entry_key, entry_ptr,        out
//           entry_fence, entry_internal, key_match, entry_count,
//           needs_split
//
// An item is taken when start is high and busy is low. Search is a binary
// search, one probe at a time through the entry memory. Insert then shifts
// the later entries up one slot; delete scans equal keys for a matching pointer
// and shifts the later entries down. The memory gives one registered read per
// cycle. Reset empties the page and idles; memory and result values are kept.
// done pulses for one cycle with the result; it cannot be stalled.
module sorted_page_entry_store #(
  parameter int unsigned CAPACITY = spes_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [spes_pkg::KEY_W-1:0]   key_in,
  input  logic [spes_pkg::PTR_W-1:0]   ptr_in,
  input  logic                         fence_in,
  input  logic                         internal_in,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [spes_pkg::POS_W-1:0]   position,
  output logic [spes_pkg::KEY_W-1:0]   entry_key,
  output logic [spes_pkg::PTR_W-1:0]   entry_ptr,
  output logic                         entry_fence,
  output logic                         entry_internal,
  output logic                         key_match,
  output logic [spes_pkg::CNT_W-1:0]   entry_count,
  output logic                         needs_split
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_BS_PROBE, S_BS_CMP, S_LK_RD, S_LK_OUT, S_INS_ADV, S_INS_SHIFT,
    S_DEL_RD, S_DEL_CHK, S_DEL_SHIFT
  } state_t;

  typedef enum logic [1:0] {OP_LOOK, OP_INS, OP_DEL} op_t;

  // Entry memory: one write and one registered read per cycle.
  spes_pkg::entry_t mem [CAPACITY];
  spes_pkg::entry_t rd_data;
  spes_pkg::entry_t wr_data;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;

  state_t           state;
  op_t              op;
  logic [1:0]       lk_status;
  logic [spes_pkg::KEY_W-1:0] key_q;
  spes_pkg::entry_t new_entry;
  logic [CW-1:0]    cnt;
  logic [IW-1:0]    lo;
  logic [IW-1:0]    hi;
  logic [IW-1:0]    off;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    rd_idx;
  logic             rd_more;
  logic             pend;
  logic [CW-1:0]    pend_idx;

  logic [IW-1:0]    mid;
  logic             ins_hit;
  logic [IW-1:0]    off_next;
  logic [CW-1:0]    cnt_inc;
  logic [CW-1:0]    cnt_dec;
  logic [CW-1:0]    idx_inc;

  assign mid = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign ins_hit = pend && (rd_data.key == key_q) && new_entry.fence && !rd_data.internal;
  assign off_next = (key_q > rd_data.key) ? IW'({1'b0, lo} + 1'b1) : lo;
  assign cnt_inc = cnt + 1'b1;
  assign cnt_dec = cnt - 1'b1;
  assign idx_inc = idx + 1'b1;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Memory port control per state.
  always_comb begin
    rd_addr = rd_idx[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = off;
    wr_data = new_entry;
    case (state)
      S_BS_PROBE: rd_addr = (hi > lo) ? mid : lo;
      S_LK_RD:    rd_addr = lo;
      S_DEL_RD:   rd_addr = idx[IW-1:0];
      S_INS_SHIFT: begin
        // Move the entry read last cycle up one slot, or drop the new one in.
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pend_idx + 1'b1);
          wr_data = ins_hit ? new_entry : rd_data;
        end else if (!rd_more) begin
          wr_en = 1'b1;
        end
      end
      S_DEL_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pend_idx - 1'b1);
          wr_data = rd_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key_q     <= key_in;
            new_entry <= '{key: key_in, ptr: ptr_in, internal: internal_in,
                           fence: fence_in};
            lo        <= '0;
            hi        <= IW'(cnt_dec);
            lk_status <= spes_pkg::ST_OK;
            pend      <= 1'b0;
            if (command == spes_pkg::CMD_INSERT && cnt >= CAP_C) begin
              op        <= OP_LOOK;
              lk_status <= spes_pkg::ST_FULL;
              state     <= S_BS_PROBE;
            end else if (command == spes_pkg::CMD_INSERT) begin
              op <= OP_INS;
              if (cnt == '0) begin
                // Empty page: place at slot zero, nothing to shift.
                off     <= '0;
                rd_more <= 1'b0;
                state   <= S_INS_SHIFT;
              end else begin
                state <= S_BS_PROBE;
              end
            end else if (cnt == '0) begin
              // Empty page: answer at once with zeroed entry fields; a delete reports not found.
              done           <= 1'b1;
              status         <= (command == spes_pkg::CMD_DELETE) ?
                                spes_pkg::ST_NOT_FOUND : spes_pkg::ST_OK;
              position       <= '0;
              entry_key      <= '0;
              entry_ptr      <= '0;
              entry_fence    <= 1'b0;
              entry_internal <= 1'b0;
              key_match      <= 1'b0;
              entry_count    <= spes_pkg::CNT_W'(cnt);
              needs_split    <= 1'b0;
            end else begin
              op    <= (command == spes_pkg::CMD_DELETE) ? OP_DEL : OP_LOOK;
              state <= S_BS_PROBE;
            end
          end
        end

        S_BS_PROBE: begin
          if (hi > lo) begin
            state <= S_BS_CMP;
          end else begin
            // Lower bound found in lo; its entry arrives next cycle.
            idx <= CW'(lo);
            case (op)
              OP_INS:  state <= S_INS_ADV;
              OP_DEL:  state <= S_DEL_CHK;
              default: state <= S_LK_OUT;
            endcase
          end
        end

        S_BS_CMP: begin
          if (key_q > rd_data.key) begin
            lo <= IW'({1'b0, mid} + 1'b1);
          end else begin
            hi <= mid;
          end
          state <= S_BS_PROBE;
        end

        S_LK_RD: state <= S_LK_OUT;

        S_LK_OUT: begin
          done           <= 1'b1;
          status         <= lk_status;
          position       <= spes_pkg::POS_W'(lo);
          entry_key      <= rd_data.key;
          entry_ptr      <= rd_data.ptr;
          entry_fence    <= rd_data.fence;
          entry_internal <= rd_data.internal;
          key_match      <= (rd_data.key == key_q);
          entry_count    <= spes_pkg::CNT_W'(cnt);
          needs_split    <= (cnt >= CAP_C);
          state          <= S_IDLE;
        end

        S_INS_ADV: begin
          // Step past the last entry when every key is smaller.
          off     <= off_next;
          rd_idx  <= cnt_dec;
          rd_more <= (CW'(off_next) < cnt);
          state   <= S_INS_SHIFT;
        end

        S_INS_SHIFT: begin
          if (ins_hit || (!pend && !rd_more)) begin
            cnt            <= cnt_inc;
            done           <= 1'b1;
            status         <= spes_pkg::ST_OK;
            position       <= ins_hit ? spes_pkg::POS_W'(pend_idx + 1'b1)
                                      : spes_pkg::POS_W'(off);
            entry_key      <= new_entry.key;
            entry_ptr      <= new_entry.ptr;
            entry_fence    <= new_entry.fence;
            entry_internal <= new_entry.internal;
            key_match      <= 1'b1;
            entry_count    <= spes_pkg::CNT_W'(cnt_inc);
            needs_split    <= (cnt_inc >= CAP_C);
            state          <= S_IDLE;
          end else begin
            pend     <= rd_more;
            pend_idx <= rd_idx;
            if (rd_more) begin
              if (rd_idx == CW'(off)) begin
                rd_more <= 1'b0;
              end else begin
                rd_idx <= rd_idx - 1'b1;
              end
            end
          end
        end

        S_DEL_RD: state <= S_DEL_CHK;

        S_DEL_CHK: begin
          if (rd_data.key != key_q) begin
            lk_status <= spes_pkg::ST_NOT_FOUND;
            state     <= S_LK_RD;
          end else if (rd_data.ptr == new_entry.ptr && !rd_data.fence) begin
            // Hold the removed entry on the outputs; close the gap.
            position       <= spes_pkg::POS_W'(idx);
            entry_key      <= rd_data.key;
            entry_ptr      <= rd_data.ptr;
            entry_fence    <= rd_data.fence;
            entry_internal <= rd_data.internal;
            key_match      <= 1'b1;
            rd_idx         <= idx_inc;
            rd_more        <= (idx_inc < cnt);
            pend           <= 1'b0;
            state          <= S_DEL_SHIFT;
          end else if (idx_inc >= cnt) begin
            lk_status <= spes_pkg::ST_NOT_FOUND;
            state     <= S_LK_RD;
          end else begin
            idx   <= idx_inc;
            state <= S_DEL_RD;
          end
        end

        S_DEL_SHIFT: begin
          if (!pend && !rd_more) begin
            cnt         <= cnt_dec;
            done        <= 1'b1;
            status      <= spes_pkg::ST_OK;
            entry_count <= spes_pkg::CNT_W'(cnt_dec);
            needs_split <= (cnt_dec >= CAP_C);
            state       <= S_IDLE;
          end else begin
            pend     <= rd_more;
            pend_idx <= rd_idx;
            if (rd_more) begin
              if (rd_idx == cnt_dec) begin
                rd_more <= 1'b0;
              end else begin
                rd_idx <= rd_idx + 1'b1;
              end
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/spes_checker.sv =====
module spes_checker #(
  parameter int unsigned CAPACITY = spes_pkg::CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [1:0]                 status,
  input logic                       needs_split,
  input logic [spes_pkg::CNT_W-1:0] entry_count
);

  a_take_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("item taken but neither worked on nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without a result");

  a_full_splits: assert property (@(posedge clk) disable iff (rst)
    (done && status == spes_pkg::ST_FULL) |-> needs_split)
    else $error("page full without split flag");

  a_split_follows_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (needs_split == (entry_count >= CAPACITY)))
    else $error("split flag disagrees with entry count");

endmodule

bind sorted_page_entry_store spes_checker #(.CAPACITY(CAPACITY)) u_spes_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .needs_split(needs_split), .entry_count(entry_count)
);
